FILE: rtl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg
// Shared types and constants of the acoustic trigger and bearing block.
// ----------------------------------------------------------------------------
package atb_pkg;

    localparam int MIC_COUNT  = 3;
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int SMP_W      = 10;
    localparam int SUM_W      = SMP_W + RING_AW;
    localparam int TIME_W     = 32;
    localparam int BRG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DEN_W      = SMP_W + 1;
    localparam int NUM_W      = 25;
    localparam int MAG_W      = 24;
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    localparam logic [SMP_W-1:0] BASE_RESET = SMP_W'(512);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASEWIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRG0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRG1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRG2      = 3'd5;

    typedef struct packed {
        logic latch;
        logic ring_rd;
        logic ring_upd;
        logic base_upd;
        logic chk;
        logic sel;
        logic mul1;
        logic mul2;
        logic wrap;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic report;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/atb_ram.sv
// ----------------------------------------------------------------------------
// atb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/atb_ctrl.sv
// ----------------------------------------------------------------------------
// atb_ctrl
// Sequencer: steps one item at a time through the datapath.
// ----------------------------------------------------------------------------
module atb_ctrl import atb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_BASE = 4'd3;
    localparam logic [3:0] ST_SEL  = 4'd4;
    localparam logic [3:0] ST_MUL1 = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_WRAP = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DEC;
                end
            end
            ST_DEC: begin
                if (!i_sts.kind) begin
                    o_cmd.ring_rd = 1'b1;
                    n_state       = ST_UPD;
                end else begin
                    o_cmd.chk = 1'b1;
                    n_state   = i_sts.report ? ST_SEL : ST_IDLE;
                end
            end
            ST_UPD: begin
                o_cmd.ring_upd = 1'b1;
                n_state        = ST_BASE;
            end
            ST_BASE: begin
                o_cmd.base_upd = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_WRAP;
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/atb_dp.sv
// ----------------------------------------------------------------------------
// atb_dp
// Datapath: configuration, sample rings, baselines, peaks, trigger state,
// bearing arithmetic with a restoring divider, and the result register.
// ----------------------------------------------------------------------------
module atb_dp import atb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_kind,
    input  logic [SMP_W-1:0]        i_sample_mic0,
    input  logic [SMP_W-1:0]        i_sample_mic1,
    input  logic [SMP_W-1:0]        i_sample_mic2,
    input  logic [TIME_W-1:0]       i_now_ms,
    input  logic                    i_out_stall,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    output logic                    o_reported,
    output logic signed [BRG_W-1:0] o_bearing_tenths,
    output logic [SMP_W-1:0]        o_peak_mic0,
    output logic [SMP_W-1:0]        o_peak_mic1,
    output logic [SMP_W-1:0]        o_peak_mic2,
    output logic [TIME_W-1:0]       o_event_time_ms
);

    // Configuration
    logic [SMP_W-1:0]        r_thr;
    logic [15:0]             r_capwin;
    logic [15:0]             r_basewin;
    logic signed [BRG_W-1:0] r_brg [MIC_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_capwin  <= 16'd100;
            r_basewin <= 16'd1000;
            r_brg[0]  <= BRG_W'(0);
            r_brg[1]  <= BRG_W'(1200);
            r_brg[2]  <= -BRG_W'(1200);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr     <= i_cfg_data[SMP_W-1:0];
                CFG_CAPTURE:   r_capwin  <= i_cfg_data;
                CFG_BASEWIN:   r_basewin <= i_cfg_data;
                CFG_BRG0:      r_brg[0]  <= i_cfg_data[BRG_W-1:0];
                CFG_BRG1:      r_brg[1]  <= i_cfg_data[BRG_W-1:0];
                CFG_BRG2:      r_brg[2]  <= i_cfg_data[BRG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Latched input item
    logic              r_kind;
    logic [SMP_W-1:0]  r_smp [MIC_COUNT];
    logic [TIME_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= i_kind;
            r_smp[0] <= i_sample_mic0;
            r_smp[1] <= i_sample_mic1;
            r_smp[2] <= i_sample_mic2;
            r_now    <= i_now_ms;
        end
    end

    // Sample rings: one row holds all three channels at one position.
    // A row not yet written reads as zero through its valid bit.
    logic [RING_AW-1:0]           r_pos;
    logic [RING_DEPTH-1:0]        r_vld;
    logic [MIC_COUNT*SMP_W-1:0]   ram_rdata;
    logic [MIC_COUNT*SMP_W-1:0]   ram_wdata;

    assign ram_wdata = {r_smp[2], r_smp[1], r_smp[0]};

    atb_ram #(
        .WIDTH (MIC_COUNT*SMP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ring_upd),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    logic [SUM_W-1:0]  r_sum   [MIC_COUNT];
    logic [SMP_W-1:0]  r_base  [MIC_COUNT];
    logic [SMP_W-1:0]  r_peak  [MIC_COUNT];
    logic              r_active;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_last;
    logic              r_rd_vld;

    logic [SMP_W-1:0]   old_smp [MIC_COUNT];
    logic [SMP_W-1:0]   mean    [MIC_COUNT];
    logic [SMP_W+1:0]   base_acc[MIC_COUNT];
    logic               base_due;
    logic               trig;
    logic [TIME_W-1:0]  ev_age;

    always_comb begin
        trig = 1'b0;
        for (int c = 0; c < MIC_COUNT; c++) begin
            old_smp[c]  = r_rd_vld ? ram_rdata[c*SMP_W +: SMP_W] : '0;
            mean[c]     = SMP_W'(r_sum[c] / SUM_W'(RING_DEPTH));
            base_acc[c] = {2'b00, r_base[c]} + {1'b0, r_base[c], 1'b0} + {2'b00, mean[c]};
            if ({1'b0, r_peak[c]} > ({1'b0, r_base[c]} + {1'b0, r_thr})) begin
                trig = 1'b1;
            end
        end
        base_due = (r_now - r_last) > {16'd0, r_basewin};
        ev_age   = r_now - r_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_vld    <= '0;
            r_active <= 1'b0;
            r_start  <= '0;
            r_last   <= '0;
            r_rd_vld <= 1'b0;
            for (int c = 0; c < MIC_COUNT; c++) begin
                r_sum[c]  <= '0;
                r_base[c] <= BASE_RESET;
                r_peak[c] <= '0;
            end
        end else begin
            if (i_cmd.ring_rd) begin
                r_rd_vld <= r_vld[r_pos];
            end
            if (i_cmd.ring_upd) begin
                r_vld[r_pos] <= 1'b1;
                r_pos        <= (r_pos == RING_AW'(RING_DEPTH - 1)) ? '0 :
                                r_pos + RING_AW'(1);
                for (int c = 0; c < MIC_COUNT; c++) begin
                    r_sum[c] <= r_sum[c] - SUM_W'(old_smp[c]) + SUM_W'(r_smp[c]);
                    if (r_smp[c] > r_peak[c]) begin
                        r_peak[c] <= r_smp[c];
                    end
                end
            end
            if (i_cmd.base_upd && base_due) begin
                r_last <= r_now;
                for (int c = 0; c < MIC_COUNT; c++) begin
                    r_base[c] <= base_acc[c][SMP_W+1:2];
                end
            end
            if (i_cmd.chk && !r_active && trig) begin
                r_active <= 1'b1;
                r_start  <= r_now;
                for (int c = 0; c < MIC_COUNT; c++) begin
                    r_peak[c] <= r_base[c];
                end
            end
            if (i_cmd.out_load) begin
                r_active <= 1'b0;
            end
        end
    end

    // Bearing: pick the two loudest channels, form the weighted sum with
    // one shared multiplier, wrap it, then divide by the amplitude sum.
    logic [1:0]              first_ch;
    logic [1:0]              second_ch;
    logic [SMP_W-1:0]        r_a1;
    logic [SMP_W-1:0]        r_a2;
    logic signed [BRG_W-1:0] r_b1;
    logic signed [BRG_W-1:0] r_b2;
    logic [DEN_W-1:0]        r_den;
    logic signed [NUM_W-1:0] r_num;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_quo;
    logic [DEN_W:0]          r_rem;
    logic [DIV_CNT_W-1:0]    r_cnt;

    logic signed [BRG_W+SMP_W:0] prod;
    logic signed [NUM_W-1:0]     lim;
    logic signed [NUM_W-1:0]     span;
    logic signed [NUM_W-1:0]     wrapped;
    logic [DEN_W+1:0]            trial;
    logic [DEN_W:0]              rem_sh;

    always_comb begin
        first_ch  = 2'd0;
        second_ch = 2'd1;
        if (r_peak[1] > r_peak[0]) begin
            first_ch  = 2'd1;
            second_ch = 2'd0;
        end
        if (r_peak[2] > r_peak[first_ch]) begin
            second_ch = first_ch;
            first_ch  = 2'd2;
        end else if (r_peak[2] > r_peak[second_ch]) begin
            second_ch = 2'd2;
        end
    end

    always_comb begin
        if (i_cmd.mul2) begin
            prod = r_b2 * $signed({1'b0, r_a2});
        end else begin
            prod = r_b1 * $signed({1'b0, r_a1});
        end
        lim  = $signed(NUM_W'(r_den) * NUM_W'(1800));
        span = $signed(NUM_W'(r_den) * NUM_W'(3600));
        if (r_num > lim) begin
            wrapped = r_num - span;
        end else if (r_num < -lim) begin
            wrapped = r_num + span;
        end else begin
            wrapped = r_num;
        end
        rem_sh = {r_rem[DEN_W-1:0], r_quo[MAG_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_a1  <= r_peak[first_ch];
            r_a2  <= r_peak[second_ch];
            r_b1  <= r_brg[first_ch];
            r_b2  <= r_brg[second_ch];
            r_den <= {1'b0, r_peak[first_ch]} + {1'b0, r_peak[second_ch]};
        end
        if (i_cmd.mul1) begin
            r_num <= NUM_W'(prod);
        end
        if (i_cmd.mul2) begin
            r_num <= r_num + NUM_W'(prod);
        end
        if (i_cmd.wrap) begin
            r_neg <= wrapped[NUM_W-1];
            r_quo <= wrapped[NUM_W-1] ? MAG_W'(-wrapped) : MAG_W'(wrapped);
            r_rem <= '0;
            r_cnt <= DIV_CNT_W'(MAG_W);
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (!trial[DEN_W+1]) begin
                r_rem <= trial[DEN_W:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[MAG_W-2:0], 1'b0};
            end
        end
    end

    // Result register
    logic                    r_ovld;
    logic signed [BRG_W-1:0] r_obrg;
    logic [SMP_W-1:0]        r_opeak [MIC_COUNT];
    logic [TIME_W-1:0]       r_otime;
    logic [BRG_W-1:0]        q_trunc;

    assign q_trunc = r_neg ? BRG_W'(-r_quo) : BRG_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_obrg  <= (r_den == '0) ? '0 : $signed(q_trunc);
            r_otime <= r_start;
            for (int c = 0; c < MIC_COUNT; c++) begin
                r_opeak[c] <= r_peak[c];
            end
        end
    end

    assign o_out_valid      = r_ovld;
    assign o_reported       = 1'b1;
    assign o_bearing_tenths = r_obrg;
    assign o_peak_mic0      = r_opeak[0];
    assign o_peak_mic1      = r_opeak[1];
    assign o_peak_mic2      = r_opeak[2];
    assign o_event_time_ms  = r_otime;

    assign o_sts.kind     = r_kind;
    assign o_sts.report   = r_active && (ev_age >= {16'd0, r_capwin});
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_busy = r_ovld && i_out_stall;

endmodule

FILE: rtl/acoustic_trigger_bearing.sv
// ----------------------------------------------------------------------------
// acoustic_trigger_bearing
// Three-microphone event detector with peak capture and bearing estimate.
// ----------------------------------------------------------------------------
// One item is worked at a time. A sample item passes through the ring read,
// ring update and baseline states, which the registered read and
// write-back of the sample ring memory call for. A check item that does not report
// returns to idle after decode; one that reports goes on through channel
// selection, two multiplies, the wrap and the 24 steps of the restoring divider
// that forms the bearing, plus any wait for the previous result to be taken. Ring entries not yet
// written read as zero through per-row valid bits, so no clearing pass is
// needed after reset.
module acoustic_trigger_bearing import atb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_kind,
    input  logic [SMP_W-1:0]        i_sample_mic0,
    input  logic [SMP_W-1:0]        i_sample_mic1,
    input  logic [SMP_W-1:0]        i_sample_mic2,
    input  logic [TIME_W-1:0]       i_now_ms,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_reported,
    output logic signed [BRG_W-1:0] o_bearing_tenths,
    output logic [SMP_W-1:0]        o_peak_mic0,
    output logic [SMP_W-1:0]        o_peak_mic1,
    output logic [SMP_W-1:0]        o_peak_mic2,
    output logic [TIME_W-1:0]       o_event_time_ms
);

    t_cmd cmd;
    t_sts sts;

    atb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    atb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_sample_mic0    (i_sample_mic0),
        .i_sample_mic1    (i_sample_mic1),
        .i_sample_mic2    (i_sample_mic2),
        .i_now_ms         (i_now_ms),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_reported       (o_reported),
        .o_bearing_tenths (o_bearing_tenths),
        .o_peak_mic0      (o_peak_mic0),
        .o_peak_mic1      (o_peak_mic1),
        .o_peak_mic2      (o_peak_mic2),
        .o_event_time_ms  (o_event_time_ms)
    );

endmodule

FILE: rtl/atb_chk.sv
// ----------------------------------------------------------------------------
// atb_chk
// Port-level checks of the acoustic trigger and bearing block.
// ----------------------------------------------------------------------------
module atb_chk import atb_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic                    o_reported,
    input logic signed [BRG_W-1:0] o_bearing_tenths,
    input logic [TIME_W-1:0]       o_event_time_ms
);

    // A fresh transfer always stalls the input in the cycle after it.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Every result carries the report flag.
    a_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_reported)
        else $error("result without report flag");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_bearing_tenths) && $stable(o_event_time_ms)))
        else $error("stalled result changed");

endmodule

bind acoustic_trigger_bearing atb_chk u_atb_chk (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the acoustic trigger and bearing block. A table of
// directed transfers is followed by random event sequences; every report is
// compared field by field with a behavioural model of the trigger machine.
// ----------------------------------------------------------------------------
module tb_top;
    import atb_pkg::*;

    typedef enum logic {KIND_SAMPLE = 1'b0, KIND_CHECK = 1'b1} t_kind;

    typedef struct {
        logic                    kind;
        logic [SMP_W-1:0]        smp [MIC_COUNT];
        logic [TIME_W-1:0]       now;
    } t_item;

    typedef struct {
        logic signed [BRG_W-1:0] bearing;
        logic [SMP_W-1:0]        peak [MIC_COUNT];
        logic [TIME_W-1:0]       when;
    } t_report;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_kind = 1'b0;
    logic [SMP_W-1:0]        i_sample_mic0 = '0, i_sample_mic1 = '0, i_sample_mic2 = '0;
    logic [TIME_W-1:0]       i_now_ms = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_reported;
    logic signed [BRG_W-1:0] o_bearing_tenths;
    logic [SMP_W-1:0]        o_peak_mic0, o_peak_mic1, o_peak_mic2;
    logic [TIME_W-1:0]       o_event_time_ms;

    acoustic_trigger_bearing uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    // Model state
    int unsigned     m_thresh, m_capture, m_basewin;
    int              m_brg [MIC_COUNT];
    int unsigned     m_ring [MIC_COUNT][RING_DEPTH];
    int unsigned     m_pos;
    int unsigned     m_sum [MIC_COUNT];
    int unsigned     m_base [MIC_COUNT];
    int unsigned     m_peak [MIC_COUNT];
    bit              m_armed;
    logic [31:0]     m_start, m_last_base;

    t_report         pending_reports [$];
    int              fail_count = 0;
    int              report_count = 0;
    int              arm_count = 0;
    bit              quiet = 1'b0;
    bit              hold_off = 1'b0;

    task automatic report_error(input string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic void model_reset();
        m_thresh = 0; m_capture = 100; m_basewin = 1000;
        m_brg[0] = 0; m_brg[1] = 1200; m_brg[2] = -1200;
        foreach (m_ring[c, k]) m_ring[c][k] = 0;
        m_pos = 0;
        for (int c = 0; c < MIC_COUNT; c++) begin
            m_sum[c] = 0; m_base[c] = 512; m_peak[c] = 0;
        end
        m_armed = 0; m_start = 0; m_last_base = 0;
    endfunction

    function automatic int pair_bearing();
        int      first, second;
        longint  a1, a2, num, den;
        first = 0; second = 1;
        if (m_peak[1] > m_peak[0]) begin
            first = 1; second = 0;
        end
        if (m_peak[2] > m_peak[first]) begin
            second = first; first = 2;
        end else if (m_peak[2] > m_peak[second]) begin
            second = 2;
        end
        a1 = m_peak[first]; a2 = m_peak[second];
        den = a1 + a2;
        if (den == 0) return 0;
        num = m_brg[first] * a1 + m_brg[second] * a2;
        if (num > 1800 * den) num -= 3600 * den;
        else if (num < -1800 * den) num += 3600 * den;
        return int'(num / den);
    endfunction

    // Advances the model by one transfer; returns 1 when a report is due.
    function automatic bit trigger_step(input t_item it, output t_report r);
        logic [31:0] dt;
        if (it.kind == KIND_SAMPLE) begin
            for (int c = 0; c < MIC_COUNT; c++) begin
                m_sum[c] = m_sum[c] - m_ring[c][m_pos] + it.smp[c];
                m_ring[c][m_pos] = it.smp[c];
                if (it.smp[c] > m_peak[c]) m_peak[c] = it.smp[c];
            end
            m_pos = (m_pos + 1) % RING_DEPTH;
            dt = it.now - m_last_base;
            if (dt > m_basewin) begin
                for (int c = 0; c < MIC_COUNT; c++)
                    m_base[c] = (m_base[c] * 3 + m_sum[c] / RING_DEPTH) / 4;
                m_last_base = it.now;
            end
            return 0;
        end
        if (m_armed) begin
            dt = it.now - m_start;
            if (dt < m_capture) return 0;
            r.bearing = BRG_W'(pair_bearing());
            for (int c = 0; c < MIC_COUNT; c++) r.peak[c] = SMP_W'(m_peak[c]);
            r.when = m_start;
            m_armed = 0;
            return 1;
        end
        for (int c = 0; c < MIC_COUNT; c++) begin
            if (m_peak[c] > m_base[c] + m_thresh) begin
                m_armed = 1;
                m_start = it.now;
                arm_count++;
                for (int j = 0; j < MIC_COUNT; j++) m_peak[j] = m_base[j];
                break;
            end
        end
        return 0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_THRESHOLD: m_thresh  = value & 32'h3FF;
            CFG_CAPTURE:   m_capture = value & 32'hFFFF;
            CFG_BASEWIN:   m_basewin = value & 32'hFFFF;
            CFG_BRG0:      m_brg[0]  = int'(signed'(BRG_W'(value)));
            CFG_BRG1:      m_brg[1]  = int'(signed'(BRG_W'(value)));
            CFG_BRG2:      m_brg[2]  = int'(signed'(BRG_W'(value)));
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one transfer and waits for it to be taken; the model runs at
    // the accepting edge. Random gaps are inserted before the offer, and
    // valid is left high so that the next item can follow at once.
    task automatic send_item(input t_item it, input bit has_exp = 0,
                             input t_report exp_r = '{default: '0});
        t_report r;
        bit      due;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= it.kind;
        i_sample_mic0 <= it.smp[0];
        i_sample_mic1 <= it.smp[1];
        i_sample_mic2 <= it.smp[2];
        i_now_ms      <= it.now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due = trigger_step(it, r);
        if (has_exp && (!due || r.bearing !== exp_r.bearing ||
                        r.when !== exp_r.when || r.peak != exp_r.peak))
            report_error("directed row does not match the expected report");
        if (due) pending_reports.push_back(r);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Output side: random stall bursts, one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            report_count++;
            if (pending_reports.size() == 0) begin
                report_error("report transfer with none expected");
            end else begin
                e = pending_reports.pop_front();
                if (o_reported !== 1'b1) report_error("reported flag low");
                if (o_bearing_tenths !== e.bearing)
                    report_error($sformatf("bearing %0d, expected %0d",
                                           o_bearing_tenths, e.bearing));
                if (o_peak_mic0 !== e.peak[0] || o_peak_mic1 !== e.peak[1] ||
                    o_peak_mic2 !== e.peak[2])
                    report_error($sformatf("peaks %0d %0d %0d, expected %0d %0d %0d",
                        o_peak_mic0, o_peak_mic1, o_peak_mic2,
                        e.peak[0], e.peak[1], e.peak[2]));
                if (o_event_time_ms !== e.when)
                    report_error($sformatf("event time %0d, expected %0d",
                                           o_event_time_ms, e.when));
            end
        end
    end

    function automatic t_item mk(input logic k, input int s0, input int s1,
                                 input int s2, input logic [31:0] t);
        t_item it;
        it.kind = k;
        it.smp[0] = SMP_W'(s0); it.smp[1] = SMP_W'(s1); it.smp[2] = SMP_W'(s2);
        it.now = t;
        return it;
    endfunction

    // One event: a run of samples, some of them loud, with stray checks, a check
    // that may arm, then one to six random items of either kind.
    task automatic random_event(inout logic [31:0] t, inout int sent);
        int n;
        n = $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
            t += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40);
            if ($urandom_range(0, 2) == 0)
                send_item(mk(KIND_SAMPLE, $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 1023), t));
            else
                send_item(mk(KIND_SAMPLE, $urandom_range(400, 620),
                             $urandom_range(400, 620), $urandom_range(400, 620), t));
            sent++;
            if ($urandom_range(0, 3) == 0) begin
                send_item(mk(KIND_CHECK, $urandom, $urandom, $urandom, t));
                sent++;
            end
        end
        t += $urandom_range(0, 80);
        send_item(mk(KIND_CHECK, $urandom, $urandom, $urandom, t));
        sent++;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            t += $urandom_range(0, 60);
            send_item(mk($urandom_range(0, 1), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 1023), t));
            sent++;
        end
    endtask

    t_item   dir_items [$];
    bit      dir_has [$];
    t_report dir_exp [$];

    initial begin
        logic [31:0] t;
        int          sent;
        t_report     r0;
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table with reset settings: loud mic 1 arms; report after
        // the 100 ms window at the extreme, with peaks equal to the baselines.
        r0.bearing = 0; r0.when = 32'd5;
        for (int c = 0; c < MIC_COUNT; c++) r0.peak[c] = 10'd512;
        r0.bearing = 12'sd600;
        dir_items = '{mk(KIND_CHECK, 0, 0, 0, 0),
                      mk(KIND_SAMPLE, 0, 1023, 0, 1),
                      mk(KIND_CHECK, 0, 0, 0, 5),
                      mk(KIND_CHECK, 0, 0, 0, 104),
                      mk(KIND_CHECK, 0, 0, 0, 105),
                      mk(KIND_SAMPLE, 1023, 1023, 1023, 32'hFFFF_FFFF),
                      mk(KIND_CHECK, 0, 0, 0, 32'hFFFF_FFFF),
                      mk(KIND_SAMPLE, 1023, 0, 1023, 32'h0000_0010),
                      mk(KIND_CHECK, 1023, 1023, 1023, 32'h0001_0000)};
        dir_has = '{0, 0, 0, 0, 1, 0, 0, 0, 0};
        dir_exp = '{r0, r0, r0, r0, r0, r0, r0, r0, r0};
        foreach (dir_items[i]) send_item(dir_items[i], dir_has[i], dir_exp[i]);
        wait_drain();

        // Zero amplitudes, zero windows, extreme bearings, wrap across +-1800.
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_CAPTURE, 0);
        write_reg(CFG_BASEWIN, 0);
        write_reg(CFG_BRG0, 1800);
        write_reg(CFG_BRG1, -1800);
        write_reg(CFG_BRG2, 1700);
        for (int i = 0; i < 70; i++)
            send_item(mk(KIND_SAMPLE, 0, 0, 0, 32'd200 + i));
        send_item(mk(KIND_SAMPLE, 1, 0, 0, 300));
        send_item(mk(KIND_CHECK, 0, 0, 0, 300));
        send_item(mk(KIND_CHECK, 0, 0, 0, 300));
        send_item(mk(KIND_SAMPLE, 900, 1000, 1000, 301));
        send_item(mk(KIND_CHECK, 0, 0, 0, 301));
        send_item(mk(KIND_SAMPLE, 1000, 1000, 0, 302));
        send_item(mk(KIND_CHECK, 0, 0, 0, 302));
        send_item(mk(KIND_CHECK, 0, 0, 0, 302));
        wait_drain();

        write_reg(CFG_THRESHOLD, 1023);
        write_reg(CFG_CAPTURE, 65535);
        write_reg(CFG_BASEWIN, 65535);
        send_item(mk(KIND_SAMPLE, 1023, 1023, 1023, 400));
        send_item(mk(KIND_CHECK, 0, 0, 0, 401));
        wait_drain();

        // Random phases with differing settings.
        t = 1000;
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_THRESHOLD, ph == 4 ? 1023 : $urandom_range(0, 300));
            write_reg(CFG_CAPTURE, ph == 3 ? 65535 : $urandom_range(0, 120));
            write_reg(CFG_BASEWIN, $urandom_range(0, 3) == 0 ? 65535 :
                                   $urandom_range(0, 200));
            write_reg(CFG_BRG0, $urandom_range(0, 3600) - 1800);
            write_reg(CFG_BRG1, $urandom_range(0, 3600) - 1800);
            write_reg(CFG_BRG2, ph == 2 ? $urandom : $urandom_range(0, 3600) - 1800);
            if (ph == 1) hold_off = 1'b1;
            if (ph == 4) quiet = 1'b1;
            while (sent < 250 * (ph + 1)) random_event(t, sent);
            wait_drain();
        end

        $display("Run covered %0d random transfers, %0d events armed, %0d reports checked.",
                 sent, arm_count, report_count);
        $display("Settings spanned threshold, window and bearing extremes, with stalls.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/atb_pkg.sv
rtl/atb_ram.sv
rtl/atb_ctrl.sv
rtl/atb_dp.sv
rtl/acoustic_trigger_bearing.sv
rtl/atb_chk.sv
test/tb_top.sv
